/* sv/slope_line_pixel_generator_top_assert.svh */
// Assertion macros for the line pixel generator.
// Used by slope_line_pixel_generator_top.sv; needs clk and rst_n in scope.
`ifndef SLOPE_LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define SLOPE_LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define SLPG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slpg assertion failed");

// Next-cycle implication, disabled during reset
`define SLPG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slpg assertion failed");

`else

`define SLPG_ASSERT_IMP(lbl, ante, cons)
`define SLPG_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* sv/slpg_pkg.sv */
// Shared constants and types for the line pixel generator.
// No dependencies.
`timescale 1ns / 1ps

package slpg_pkg;

  // Screen coordinate width
  localparam int COORD_BITS = 12;

  // Radix-4 multiplier digits and shared step counter width
  localparam int MUL_DIGITS = (COORD_BITS + 1) / 2;
  localparam int CNT_W      = $clog2(COORD_BITS);

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

endpackage

/* sv/slope_line_pixel_generator_top.sv */
// Line pixel generator: latches a line on load, emits one pixel per step.
// Flow: a load is latched while idle; a vertical step captures the pixel, then hands
// it to the output register; a sloped step runs the radix-4 serial multiplier and
// the one-bit-per-cycle restoring divider, sharing one register, before that hand-off.
// Throughput: one transaction at a time; a load every cycle while idle, a new step
// only once the last pixel reached the output register (held while the output stalls).
// Reset (rst_n, synchronous, active low) clears the line and the output valid.
`timescale 1ns / 1ps
`include "slope_line_pixel_generator_top_assert.svh"

module slope_line_pixel_generator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [slpg_pkg::COORD_BITS-1:0] in_x_start,
  input  logic [slpg_pkg::COORD_BITS-1:0] in_y_start,
  input  logic [slpg_pkg::COORD_BITS-1:0] in_x_end,
  input  logic [slpg_pkg::COORD_BITS-1:0] in_y_end,
  input  logic [31:0]                    in_line_color,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [slpg_pkg::COORD_BITS-1:0] out_pixel_x,
  output logic [slpg_pkg::COORD_BITS-1:0] out_pixel_y,
  output logic [31:0]                    out_pixel_color,
  output logic                           out_last_pixel
);

  localparam int C  = slpg_pkg::COORD_BITS;
  localparam int MD = slpg_pkg::MUL_DIGITS;
  localparam int CW = slpg_pkg::CNT_W;

  // Control state
  slpg_pkg::state_t state_r, state_nxt;
  logic             active_r, active_nxt;
  logic             vert_r, vert_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Line state
  logic [C-1:0]     x0_r, x0_nxt;
  logic [C-1:0]     y0_r, y0_nxt;
  logic [C-1:0]     x1_r, x1_nxt;
  logic [C-1:0]     y1_r, y1_nxt;
  logic [C-1:0]     walk_r, walk_nxt;
  logic [31:0]      color_r, color_nxt;
  logic             xneg_r, xneg_nxt;
  logic             dyneg_r, dyneg_nxt;
  logic [C-1:0]     dx_r, dx_nxt;
  logic [C-1:0]     dy_r, dy_nxt;
  logic [C+1:0]     dy3_r, dy3_nxt;

  // Per-pixel working registers
  logic [2*MD-1:0]  mk_r, mk_nxt;
  logic [2*C-1:0]   acc_r, acc_nxt;
  logic [C-1:0]     px_r, px_nxt;
  logic [C-1:0]     py_r, py_nxt;
  logic             last_r, last_nxt;

  // Output register
  logic [C-1:0]     opx_r, opx_nxt;
  logic [C-1:0]     opy_r, opy_nxt;
  logic [31:0]      ocol_r, ocol_nxt;
  logic             olast_r, olast_nxt;

  // Combinational helpers
  logic             in_acc;
  logic [C-1:0]     abs_dy, abs_dx, kval, goal, walk_adv;
  logic [2*C-1:0]   pp;
  logic [C:0]       rem_sh;
  logic [C+1:0]     diff;
  logic [C-1:0]     quo, rem, qfix, py_calc, py_fin;

  assign in_acc = in_valid && !in_stall;

  // Absolute deltas of the incoming line
  assign abs_dy = (in_y_end >= in_y_start) ? (in_y_end - in_y_start) : (in_y_start - in_y_end);
  assign abs_dx = (in_x_end >= in_x_start) ? (in_x_end - in_x_start) : (in_x_start - in_x_end);

  // Distance walked from the first endpoint, always non-negative
  assign kval = xneg_r ? (x0_r - walk_r) : (walk_r - x0_r);

  // Walk advance toward the goal coordinate
  assign goal     = vert_r ? y1_r : x1_r;
  assign walk_adv = (walk_r < goal) ? (walk_r + C'(1)) : (walk_r - C'(1));

  // Radix-4 partial product selected by the top multiplier digit
  always_comb begin
    case (mk_r[2*MD-1 -: 2])
      2'd0:    pp = '0;
      2'd1:    pp = (2*C)'(dy_r);
      2'd2:    pp = (2*C)'({dy_r, 1'b0});
      default: pp = (2*C)'(dy3_r);
    endcase
  end

  // Restoring division step: remainder in the upper half, dividend/quotient below
  assign rem_sh = {acc_r[2*C-1:C], acc_r[C-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dx_r};

  // Floor correction for a falling line: round the magnitude up
  assign quo     = acc_r[C-1:0];
  assign rem     = acc_r[2*C-1:C];
  assign qfix    = quo + C'(rem != '0);
  assign py_calc = dyneg_r ? (y0_r - qfix) : (y0_r + quo);
  assign py_fin  = vert_r ? py_r : py_calc;

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    vert_nxt      = vert_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    walk_nxt      = walk_r;
    color_nxt     = color_r;
    xneg_nxt      = xneg_r;
    dyneg_nxt     = dyneg_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dy3_nxt       = dy3_r;
    mk_nxt        = mk_r;
    acc_nxt       = acc_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    opx_nxt       = opx_r;
    opy_nxt       = opy_r;
    ocol_nxt      = ocol_r;
    olast_nxt     = olast_r;
    in_stall      = (state_r != slpg_pkg::S_IDLE);

    unique case (state_r)
      slpg_pkg::S_IDLE: begin
        if (in_acc && (in_operation == slpg_pkg::OP_LOAD)) begin
          // latch a new line
          x0_nxt    = in_x_start;
          y0_nxt    = in_y_start;
          x1_nxt    = in_x_end;
          y1_nxt    = in_y_end;
          color_nxt = in_line_color;
          xneg_nxt  = (in_x_end < in_x_start);
          dyneg_nxt = (in_y_end < in_y_start);
          dx_nxt    = abs_dx;
          dy_nxt    = abs_dy;
          dy3_nxt   = (C+2)'(abs_dy) + (C+2)'({abs_dy, 1'b0});
          if (in_x_start == in_x_end) begin
            vert_nxt   = 1'b1;
            walk_nxt   = in_y_start;
            active_nxt = (in_y_start != in_y_end);
          end else begin
            vert_nxt   = 1'b0;
            walk_nxt   = in_x_start;
            active_nxt = 1'b1;
          end
        end else if (in_acc && active_r) begin
          // step: capture pixel, advance the walk
          walk_nxt = walk_adv;
          last_nxt = (walk_adv == goal);
          if (walk_adv == goal) begin
            active_nxt = 1'b0;
          end
          if (vert_r) begin
            px_nxt    = x0_r;
            py_nxt    = walk_r;
            state_nxt = slpg_pkg::S_FIN;
          end else begin
            px_nxt    = walk_r;
            mk_nxt    = (2*MD)'(kval);
            acc_nxt   = '0;
            cnt_nxt   = CW'(MD - 1);
            state_nxt = slpg_pkg::S_MUL;
          end
        end
      end

      slpg_pkg::S_MUL: begin
        // |dy| * k, two multiplier bits per cycle
        acc_nxt = {acc_r[2*C-3:0], 2'b00} + pp;
        mk_nxt  = {mk_r[2*MD-3:0], 2'b00};
        if (cnt_r == '0) begin
          cnt_nxt   = CW'(C - 1);
          state_nxt = slpg_pkg::S_DIV;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end

      slpg_pkg::S_DIV: begin
        // one quotient bit per cycle
        if (!diff[C+1]) begin
          acc_nxt = {diff[C-1:0], acc_r[C-2:0], 1'b1};
        end else begin
          acc_nxt = {rem_sh[C-1:0], acc_r[C-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = slpg_pkg::S_FIN;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end

      slpg_pkg::S_FIN: begin
        // hand the pixel to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          opx_nxt       = px_r;
          opy_nxt       = py_fin;
          ocol_nxt      = color_r;
          olast_nxt     = last_r;
          out_valid_nxt = 1'b1;
          state_nxt     = slpg_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = slpg_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slpg_pkg::S_IDLE;
      active_r    <= 1'b0;
      vert_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      x0_r        <= '0;
      y0_r        <= '0;
      x1_r        <= '0;
      y1_r        <= '0;
      walk_r      <= '0;
      color_r     <= '0;
      xneg_r      <= 1'b0;
      dyneg_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      vert_r      <= vert_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      x0_r        <= x0_nxt;
      y0_r        <= y0_nxt;
      x1_r        <= x1_nxt;
      y1_r        <= y1_nxt;
      walk_r      <= walk_nxt;
      color_r     <= color_nxt;
      xneg_r      <= xneg_nxt;
      dyneg_r     <= dyneg_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    dy3_r   <= dy3_nxt;
    mk_r    <= mk_nxt;
    acc_r   <= acc_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    last_r  <= last_nxt;
    opx_r   <= opx_nxt;
    opy_r   <= opy_nxt;
    ocol_r  <= ocol_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = opx_r;
  assign out_pixel_y     = opy_r;
  assign out_pixel_color = ocol_r;
  assign out_last_pixel  = olast_r;

  // A sloped step always starts the multiplier
  `SLPG_ASSERT_NXT(a_slope_starts_mul, in_acc && (in_operation == slpg_pkg::OP_STEP) && active_r && !vert_r, state_r == slpg_pkg::S_MUL)
  // Partial remainder stays below the divisor throughout the division
  `SLPG_ASSERT_IMP(a_rem_below_dx, state_r == slpg_pkg::S_DIV, acc_r[2*C-1:C] < dx_r)
  // A new result only ever comes out of the finishing state
  `SLPG_ASSERT_IMP(a_out_from_fin, $rose(out_valid_r), $past(state_r) == slpg_pkg::S_FIN)
  // An active sloped line never has a zero x span
  `SLPG_ASSERT_IMP(a_dx_nonzero, active_r && !vert_r && (state_r == slpg_pkg::S_MUL), dx_r != '0)

endmodule
